@@ hw/rtl/mmp_pkg.sv @@
package mmp_pkg;

   // Field widths of the request and response channels.
   localparam int unsigned OperandWidth       = 62;
   localparam int unsigned ResidueWidth       = 30;
   localparam int unsigned DefaultOperandBits = 62;

   // Datapath widths: one shared 32 x 32 multiplier, values below 2^60 to reduce.
   localparam int unsigned MulWidth     = 32;
   localparam int unsigned ProductWidth = 2 * MulWidth;
   localparam int unsigned ReduceWidth  = 2 * ResidueWidth;

   // Prime modulus and the constants derived from it.
   localparam logic [ResidueWidth-1:0] Modulus   = 30'd1000000007;
   localparam logic [MulWidth-1:0]     ModulusX2 = 32'd2000000014;
   // 2^30 mod p, used to fold the upper half of a wide operand.
   localparam logic [ResidueWidth-1:0] FoldConst = 30'd73741817;
   // Barrett factor floor(2^60 / p), worked out at elaboration.
   localparam logic [63:0] BarrettMuWide = (64'd1 << ReduceWidth) / 64'(Modulus);
   localparam logic [ResidueWidth:0]   BarrettMu = BarrettMuWide[ResidueWidth:0];

   // Operand selection for the shared multiplier.
   localparam logic [1:0] MulOperands = 2'd0;
   localparam logic [1:0] MulMu       = 2'd1;
   localparam logic [1:0] MulModulus  = 2'd2;

   // Load selection for the value under reduction.
   localparam logic [1:0] XHold    = 2'd0;
   localparam logic [1:0] XSeed    = 2'd1;
   localparam logic [1:0] XProduct = 2'd2;

   typedef struct packed {
      logic [1:0] mul_sel;
      logic [1:0] x_sel;
   } mmp_ctrl_type;

endpackage

@@ hw/rtl/mmp_channels.sv @@
// Request channel: opcode and two operands.
interface mmp_req_if;
   import mmp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    op;
   logic [OperandWidth-1:0] operand_a;
   logic [OperandWidth-1:0] operand_b;

   modport source (output valid, output op, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b,
                   output ready);
endinterface

// Response channel: one residue per request.
interface mmp_rsp_if;
   import mmp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ResidueWidth-1:0] residue;

   modport source (output valid, output residue, input ready);
   modport sink   (input valid, input residue, output ready);
endinterface

@@ hw/rtl/modular_multiply_and_power.sv @@
// A multiply reduces both operands, forms their modular product and hands it over; a power
// reduces the base, squares once per exponent bit, multiplies per set bit and hands over.
// Each modular product uses the shared 32 x 32 multiplier thrice, plus transfer and fix-up.
// Only one request is in flight at a time;
// a new request is taken while a response waits, a finished one waits for the response slot.
// Reset (synchronous, active high) returns the sequencer to idle and drops the response.
module modular_multiply_and_power #(
   parameter int unsigned OPERAND_BITS = mmp_pkg::DefaultOperandBits
) (
   input logic        clock,
   input logic        reset,
   mmp_req_if.sink    req_bus,
   mmp_rsp_if.source  rsp_bus
);
   import mmp_pkg::*;

   localparam int unsigned IdxBits = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
   localparam logic [OperandWidth-1:0] OperandMask =
      (OperandWidth'(1) << OPERAND_BITS) - OperandWidth'(1);

   // Sequencer states.
   localparam logic [2:0] SIdle   = 3'd0;
   localparam logic [2:0] SMul    = 3'd1;
   localparam logic [2:0] SXfer   = 3'd2;
   localparam logic [2:0] SMu     = 3'd3;
   localparam logic [2:0] SQp     = 3'd4;
   localparam logic [2:0] SFix    = 3'd5;
   localparam logic [2:0] SFinish = 3'd6;

   // What the current reduction computes.
   localparam logic [2:0] PhAHigh = 3'd0;
   localparam logic [2:0] PhALow  = 3'd1;
   localparam logic [2:0] PhBHigh = 3'd2;
   localparam logic [2:0] PhBLow  = 3'd3;
   localparam logic [2:0] PhDone  = 3'd4;
   localparam logic [2:0] PhSq    = 3'd5;
   localparam logic [2:0] PhMulB  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [2:0]              phase_ff, phase_in;
   logic                    op_ff, op_in;
   logic [OPERAND_BITS-1:0] exp_ff, exp_in;
   logic [IdxBits-1:0]      idx_ff, idx_in;
   logic [ResidueWidth-1:0] base_ff, base_in;
   logic [ResidueWidth-1:0] acc_ff, acc_in;
   logic [ResidueWidth-1:0] opu_ff, opu_in;
   logic [ResidueWidth-1:0] opv_ff, opv_in;
   logic [ResidueWidth-1:0] addend_ff, addend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ResidueWidth-1:0] rsp_residue_ff, rsp_residue_in;

   logic                    accept;
   logic [OperandWidth-1:0] a_masked;
   logic [OperandWidth-1:0] exp_wide;
   logic [ReduceWidth-1:0]  x_seed;
   logic [ResidueWidth-1:0] residue;
   mmp_ctrl_type            ctrl;

   assign req_bus.ready   = (state_ff == SIdle);
   assign accept          = req_bus.valid & req_bus.ready;
   assign a_masked        = req_bus.operand_a & OperandMask;
   assign exp_wide        = OperandWidth'(exp_ff);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.residue = rsp_residue_ff;

   mmp_datapath u_datapath (
      .clock   (clock),
      .ctrl    (ctrl),
      .x_seed  (x_seed),
      .opu     (opu_ff),
      .opv     (opv_ff),
      .addend  (addend_ff),
      .residue (residue)
   );

   // Sequencer and operand registers.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      op_in          = op_ff;
      exp_in         = exp_ff;
      idx_in         = idx_ff;
      base_in        = base_ff;
      acc_in         = acc_ff;
      opu_in         = opu_ff;
      opv_in         = opv_ff;
      addend_in      = addend_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_bus.ready;
      rsp_residue_in = rsp_residue_ff;
      x_seed         = ReduceWidth'(a_masked[OperandWidth-1:ResidueWidth]);
      ctrl.mul_sel   = MulOperands;
      ctrl.x_sel     = XHold;

      unique case (state_ff)
         SIdle: begin
            // Start by reducing the upper part of the base; its lower part waits as addend.
            if (accept) begin
               op_in      = req_bus.op;
               exp_in     = req_bus.operand_b[OPERAND_BITS-1:0];
               addend_in  = a_masked[ResidueWidth-1:0];
               phase_in   = PhAHigh;
               ctrl.x_sel = XSeed;
               state_in   = SMu;
            end
         end
         SMul: begin
            ctrl.mul_sel = MulOperands;
            state_in     = SXfer;
         end
         SXfer: begin
            ctrl.x_sel = XProduct;
            state_in   = SMu;
         end
         SMu: begin
            ctrl.mul_sel = MulMu;
            state_in     = SQp;
         end
         SQp: begin
            ctrl.mul_sel = MulModulus;
            state_in     = SFix;
         end
         SFix: begin
            state_in = SMul;
            case (phase_ff) inside
               PhAHigh, PhBHigh: begin
                  // Fold the reduced upper half back in: hi * 2^30 + lo.
                  opu_in   = residue;
                  opv_in   = FoldConst;
                  phase_in = (phase_ff == PhAHigh) ? PhALow : PhBLow;
               end
               PhALow: begin
                  base_in = residue;
                  if (!op_ff) begin
                     x_seed     = ReduceWidth'(exp_wide[OperandWidth-1:ResidueWidth]);
                     ctrl.x_sel = XSeed;
                     addend_in  = exp_wide[ResidueWidth-1:0];
                     phase_in   = PhBHigh;
                     state_in   = SMu;
                  end else begin
                     // Power starts from one and squares once per exponent bit.
                     acc_in    = ResidueWidth'(1);
                     opu_in    = ResidueWidth'(1);
                     opv_in    = ResidueWidth'(1);
                     addend_in = '0;
                     idx_in    = IdxBits'(OPERAND_BITS - 1);
                     phase_in  = PhSq;
                  end
               end
               PhBLow: begin
                  opu_in    = base_ff;
                  opv_in    = residue;
                  addend_in = '0;
                  phase_in  = PhDone;
               end
               PhDone: begin
                  acc_in   = residue;
                  state_in = SFinish;
               end
               PhSq: begin
                  acc_in = residue;
                  if (exp_ff[idx_ff]) begin
                     opu_in   = residue;
                     opv_in   = base_ff;
                     phase_in = PhMulB;
                  end else if (idx_ff == '0) begin
                     state_in = SFinish;
                  end else begin
                     idx_in = idx_ff - IdxBits'(1);
                     opu_in = residue;
                     opv_in = residue;
                  end
               end
               default: begin
                  // Multiply by the base done; move to the next exponent bit.
                  acc_in = residue;
                  if (idx_ff == '0) begin
                     state_in = SFinish;
                  end else begin
                     idx_in   = idx_ff - IdxBits'(1);
                     opu_in   = residue;
                     opv_in   = residue;
                     phase_in = PhSq;
                  end
               end
            endcase
         end
         SFinish: begin
            // Hand the result to the response register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_residue_in = acc_ff;
               state_in       = SIdle;
            end
         end
         default: begin
            state_in = SIdle;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      phase_ff       <= phase_in;
      op_ff          <= op_in;
      exp_ff         <= exp_in;
      idx_ff         <= idx_in;
      base_ff        <= base_in;
      acc_ff         <= acc_in;
      opu_ff         <= opu_in;
      opv_ff         <= opv_in;
      addend_ff      <= addend_in;
      rsp_residue_ff <= rsp_residue_in;
   end

endmodule

@@ hw/rtl/mmp_datapath.sv @@
module mmp_datapath (
   input  logic                              clock,
   input  mmp_pkg::mmp_ctrl_type             ctrl,
   input  logic [mmp_pkg::ReduceWidth-1:0]   x_seed,
   input  logic [mmp_pkg::ResidueWidth-1:0]  opu,
   input  logic [mmp_pkg::ResidueWidth-1:0]  opv,
   input  logic [mmp_pkg::ResidueWidth-1:0]  addend,
   output logic [mmp_pkg::ResidueWidth-1:0]  residue
);
   import mmp_pkg::*;

   logic [MulWidth-1:0]     mul_a;
   logic [MulWidth-1:0]     mul_b;
   logic [ProductWidth-1:0] prod_ff;
   logic [ProductWidth-1:0] prod_in;
   logic [ReduceWidth-1:0]  x_ff;
   logic [ReduceWidth-1:0]  x_in;
   logic [MulWidth-1:0]     diff;

   // Operand selection for the one shared multiplier.
   always_comb begin
      unique case (ctrl.mul_sel)
         MulMu: begin
            mul_a = {1'b0, x_ff[ReduceWidth-1:ResidueWidth-1]};
            mul_b = {1'b0, BarrettMu};
         end
         MulModulus: begin
            mul_a = {1'b0, prod_ff[2*ResidueWidth+1:ResidueWidth+1]};
            mul_b = {2'b00, Modulus};
         end
         default: begin
            mul_a = {2'b00, opu};
            mul_b = {2'b00, opv};
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // The value under reduction is seeded directly or taken from a product plus an addend.
   always_comb begin
      unique case (ctrl.x_sel)
         XSeed:    x_in = x_seed;
         XProduct: x_in = prod_ff[ReduceWidth-1:0] + ReduceWidth'(addend);
         default:  x_in = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= x_in;
   end

   // Barrett remainder x - q*p lies below 3p; at most one of two corrections applies.
   assign diff = x_ff[MulWidth-1:0] - prod_ff[MulWidth-1:0];

   always_comb begin
      if (diff >= ModulusX2) begin
         residue = ResidueWidth'(diff - ModulusX2);
      end else if (diff >= MulWidth'(Modulus)) begin
         residue = ResidueWidth'(diff - MulWidth'(Modulus));
      end else begin
         residue = ResidueWidth'(diff);
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import mmp_pkg::*;

   // Opcodes of the request channel.
   localparam logic OpMultiply = 1'b0;
   localparam logic OpPower    = 1'b1;

   localparam longint unsigned     Prime      = 64'(Modulus);
   localparam logic [OperandWidth-1:0] OperandMax = '1;
   localparam logic [OperandWidth-1:0] AltOnes    = OperandWidth'(64'hAAAA_AAAA_AAAA_AAAA);
   localparam logic [OperandWidth-1:0] AltZeros   = OperandWidth'(64'h5555_5555_5555_5555);

   localparam int unsigned ItemsPerPhase = 576;
   localparam int unsigned HoldCycles    = 2000;
   localparam int unsigned SettleCycles  = 700;
   localparam int unsigned StallLimit    = 10000;

   // Keeps the residues still owed by the block, oldest first.
   class residue_scoreboard;
      logic [ResidueWidth-1:0] owed_q[$];
      int unsigned mismatches;
      int unsigned matched;
      int unsigned multiplies;
      int unsigned powers;

      // Residue of one request, using full-width products of reduced values.
      function logic [ResidueWidth-1:0] residue_of(logic op, logic [OperandWidth-1:0] a,
                                                   logic [OperandWidth-1:0] b);
         longint unsigned base;
         longint unsigned acc;
         base = 64'(a) % Prime;
         if (op == OpMultiply) begin
            acc = base * (64'(b) % Prime) % Prime;
         end else begin
            acc = 1;
            for (int i = OperandWidth - 1; i >= 0; i--) begin
               acc = acc * acc % Prime;
               if (b[i]) begin
                  acc = acc * base % Prime;
               end
            end
         end
         return acc[ResidueWidth-1:0];
      endfunction

      function void note_request(logic op, logic [OperandWidth-1:0] a,
                                 logic [OperandWidth-1:0] b);
         owed_q.insert(owed_q.size(), residue_of(op, a, b));
         if (op == OpMultiply) begin
            multiplies++;
         end else begin
            powers++;
         end
      endfunction

      function void check_response(logic [ResidueWidth-1:0] residue);
         logic [ResidueWidth-1:0] want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %0d", $time, residue);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         if (residue !== want) begin
            $display("%0t: residue mismatch, expected %0d, got %0d", $time, want, residue);
            mismatches++;
         end else begin
            matched++;
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   mmp_req_if req_bus ();
   mmp_rsp_if rsp_bus ();

   modular_multiply_and_power u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   residue_scoreboard board = new();

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_wanted;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Operand drawn from a few classes: full width, small, around the modulus,
   // multiples of the modulus, already reduced, and of random length.
   function automatic logic [OperandWidth-1:0] random_operand();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(5))
         0: return wide[OperandWidth-1:0];
         1: return OperandWidth'(wide[9:0]);
         2: return OperandWidth'(Prime - 3 + $urandom_range(6));
         3: return OperandWidth'(Prime * 64'($urandom));
         4: return OperandWidth'(wide % Prime);
         default: return wide[OperandWidth-1:0] >> $urandom_range(61);
      endcase
   endfunction

   // Offers one request, after a random gap, and notes it once it is taken.
   task automatic send_request(input logic op, input logic [OperandWidth-1:0] a,
                               input logic [OperandWidth-1:0] b);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(400, 20) : $urandom_range(6, 1);
      end
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_request(op, a, b);
   endtask

   // Stops offering requests and waits until every owed residue has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Response side: checks each response taken, and drives ready with random
   // stalls or, once asked, one long hold-off.
   initial begin : response_sink
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.ready && rsp_bus.valid === 1'b1) begin
            board.check_response(rsp_bus.residue);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left   = HoldCycles - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
               $display("%0t: timeout, no request or response for %0d cycles", $time,
                        StallLimit);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // Main sequence: reset, directed requests, then three phases of random ones.
   initial begin : stimulus
      req_bus.valid     = 1'b0;
      req_bus.op        = OpMultiply;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      reset             = 1'b1;
      hold_wanted       = 1'b0;
      send_idle_pct     = 34;
      recv_idle_pct     = 47;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Extremes, zero multiplier and exponent, operands at or above the modulus.
      send_request(OpMultiply, '0, '0);
      send_request(OpMultiply, OperandMax, OperandMax);
      send_request(OpMultiply, OperandMax, '0);
      send_request(OpMultiply, OperandWidth'(Prime), 5);
      send_request(OpMultiply, OperandWidth'(Prime - 1), OperandWidth'(Prime - 1));
      send_request(OpMultiply, OperandWidth'(Prime + 1), OperandMax);
      send_request(OpMultiply, OperandWidth'(2 * Prime), 123);
      send_request(OpMultiply, 1, OperandMax);
      send_request(OpMultiply, AltOnes, AltZeros);
      send_request(OpMultiply, OperandWidth'(Prime), OperandMax);
      send_request(OpPower, '0, '0);
      send_request(OpPower, OperandWidth'(Prime), '0);
      send_request(OpPower, OperandWidth'(3 * Prime), '0);
      send_request(OpPower, OperandMax, '0);
      send_request(OpPower, '0, OperandMax);
      send_request(OpPower, OperandWidth'(Prime), 5);
      send_request(OpPower, 2, 1);
      send_request(OpPower, OperandWidth'(Prime - 1), OperandMax);
      send_request(OpPower, OperandMax, OperandMax);
      send_request(OpPower, 2, OperandWidth'(Prime - 1));
      send_request(OpPower, AltZeros, AltOnes);
      send_request(OpPower, 1, random_operand());

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < ItemsPerPhase; n++) begin
            // One long response hold-off while requests keep coming.
            if (phase == 0 && n == 150) begin
               hold_wanted = 1'b1;
            end
            send_request($urandom_range(1) ? OpPower : OpMultiply, random_operand(),
                         random_operand());
         end
         drain_responses();
      end

      repeat (SettleCycles) @(posedge clock);
      $display("Covered %0d multiplies and %0d powers; %0d residues matched.",
               board.multiplies, board.powers, board.matched);
      $display("Stalls on either side, one long response hold-off and full-rate traffic.");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/mmp_pkg.sv
hw/rtl/mmp_channels.sv
hw/rtl/mmp_datapath.sv
hw/rtl/modular_multiply_and_power.sv
tb/sv/testbench.sv
